// ===== src/dc2d_pkg.sv =====
package dc2d_pkg;

	// Field widths
	localparam int DAY_W   = 23;	// signed day count
	localparam int MAG_W   = DAY_W - 1;	// magnitude of a non-negative count
	localparam int YEAR_W  = 14;
	localparam int DOY_W   = 9;	// 0-based day of year, up to 365
	localparam int MON_W   = 4;
	localparam int DOM_W   = 5;
	localparam int DATE_W  = 27;
	localparam int YMUL_W  = 28;

	localparam int unsigned BASE_YEAR = 1601;
	localparam int unsigned BASE_MOD4   = BASE_YEAR % 4;
	localparam int unsigned BASE_MOD100 = BASE_YEAR % 100;
	localparam int unsigned BASE_MOD400 = BASE_YEAR % 400;

	// Block lengths in days
	localparam int unsigned DAYS_400Y = 146097;
	localparam int unsigned DAYS_100Y = 36524;
	localparam int unsigned DAYS_4Y   = 1461;
	localparam int unsigned DAYS_1Y   = 365;

	localparam int unsigned YEARS_400 = 400;
	localparam int unsigned YEARS_100 = 100;
	localparam int unsigned DEC_YEAR  = 10000;
	localparam int unsigned DEC_MONTH = 100;

	// Reciprocals for exact division by constant: q = (x * RCP) >> SH
	localparam int SH_400Y = 40;
	localparam logic [22:0] RCP_400Y =
		23'(((64'd1 << SH_400Y) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
	localparam int SH_4Y = 27;
	localparam logic [16:0] RCP_4Y =
		17'(((64'd1 << SH_4Y) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

	localparam int Q400_W = 5;	// at most 28 whole 400-year blocks
	localparam int Q4_W   = 5;	// at most 24 whole 4-year blocks

	// First day of each month, 0-based day of year
	localparam logic [DOY_W-1:0] CUM_LEAP [13] = '{
		9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};
	localparam logic [DOY_W-1:0] CUM_NORM [13] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};

	// Year and day of year handed from the block split to the date stages
	typedef struct packed {
		logic              err;
		logic [YEAR_W-1:0] year;
		logic              leap;
		logic [DOY_W-1:0]  doy;
	} ydoy_t;

endpackage

// ===== src/day_count_to_yyyymmdd.sv =====
// Gregorian day count (0 = January 1, 1601) to packed decimal YYYYMMDD.
// Each accepted input item passes through stage registers s1 to s8 in order before its result reaches m_axis.
// Throughput: one item per cycle while m_axis_tready is high; the eight-stage pipeline holds up to eight items.
// Stalls on m_axis back up stage by stage; every stage register holds its item.
// Reset (arst_n low) clears the stage valid bits only; no warm-up is needed.
module day_count_to_yyyymmdd (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,	// [22:0] day_count (signed), [23] zero
	// Output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,	// [26:0] packed_date, [31:27] zero
	output logic [0:0]  m_axis_tuser	// [0] error
);
	import dc2d_pkg::*;

	// Between the year split and the month/day stages
	logic  split_valid;
	logic  split_ready;
	ydoy_t split_item;

	logic [DATE_W-1:0] date;
	logic              err;

	// Stages 1-6: peel off 400-year, century, 4-year and single-year blocks.
	// The 400-year and 4-year quotients come from exact reciprocal products;
	// the century and single-year counts (at most 3) from three compares.
	// A negative count only raises the error flag that rides along.
	dc2d_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.neg       (s_axis_tdata[DAY_W-1]),
		.mag       (s_axis_tdata[MAG_W-1:0]),
		.out_valid (split_valid),
		.out_ready (split_ready),
		.out_item  (split_item)
	);

	// Stages 7-8: month and day from the first-of-month tables (leap table
	// for leap years), then fold year, month and day into decimal YYYYMMDD.
	// The error flag forces the packed date to zero.
	dc2d_date u_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (split_ready),
		.in_item   (split_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_date  (date),
		.out_err   (err)
	);

	// Pad the date to whole bytes
	assign m_axis_tdata = {5'd0, date};
	assign m_axis_tuser = err;

endmodule

// ===== src/dc2d_split.sv =====
module dc2d_split (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       neg,
	input  logic [dc2d_pkg::MAG_W-1:0] mag,
	output logic                       out_valid,
	input  logic                       out_ready,
	output dc2d_pkg::ydoy_t            out_item
);
	import dc2d_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	// Stage 1: reciprocal product for the 400-year split
	logic                err_s1;
	logic [MAG_W-1:0]    mag_s1;
	logic [44:0]         prod_s1;
	// Stage 2: remainder inside the 400-year block
	logic                err_s2;
	logic [17:0]         r400_s2;
	logic [YEAR_W-1:0]   yoff_s2;
	// Stage 3: century split
	logic                err_s3;
	logic [15:0]         r100_s3;
	logic [YEAR_W-1:0]   yoff_s3;
	logic [1:0]          n100_s3;
	// Stage 4: reciprocal product for the 4-year split
	logic                err_s4;
	logic [15:0]         r100_s4;
	logic [YEAR_W-1:0]   yoff_s4;
	logic [1:0]          n100_s4;
	logic [31:0]         prod_s4;
	// Stage 5: remainder inside the 4-year block, leap residues
	logic                err_s5;
	logic [10:0]         r4_s5;
	logic [YEAR_W-1:0]   yoff_s5;
	logic [7:0]          p100_s5;
	logic [9:0]          p400_s5;
	// Stage 6
	ydoy_t               item_s6;

	logic [Q400_W-1:0]   n400;
	logic [1:0]          n100;
	logic [Q4_W-1:0]     n4;
	logic [1:0]          n1;
	logic [1:0]          m4;
	logic [7:0]          s100, mod100;
	logic [9:0]          s400, mod400;

	assign adv_s6   = !v_s6 || out_ready;
	assign adv_s5   = !v_s5 || adv_s6;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
			if (adv_s6) v_s6 <= v_s5;
		end
	end

	always_comb begin
		n400 = prod_s1[SH_400Y +: Q400_W];

		if (r400_s2 >= 18'(3 * DAYS_100Y))
			n100 = 2'd3;
		else if (r400_s2 >= 18'(2 * DAYS_100Y))
			n100 = 2'd2;
		else if (r400_s2 >= 18'(DAYS_100Y))
			n100 = 2'd1;
		else
			n100 = 2'd0;

		n4 = prod_s4[SH_4Y +: Q4_W];

		if (r4_s5 >= 11'(3 * DAYS_1Y))
			n1 = 2'd3;
		else if (r4_s5 >= 11'(2 * DAYS_1Y))
			n1 = 2'd2;
		else if (r4_s5 >= 11'(DAYS_1Y))
			n1 = 2'd1;
		else
			n1 = 2'd0;

		// year mod 4, 100 and 400 from the block counts
		m4     = 2'(BASE_MOD4) + n1;
		s100   = p100_s5 + 8'(n1);
		mod100 = (s100 >= 8'(YEARS_100)) ? 8'(s100 - 8'(YEARS_100)) : s100;
		s400   = p400_s5 + 10'(n1);
		mod400 = (s400 >= 10'(YEARS_400)) ? 10'(s400 - 10'(YEARS_400)) : s400;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s1  <= neg;
			mag_s1  <= mag;
			prod_s1 <= 45'(45'(mag) * 45'(RCP_400Y));
		end
		if (adv_s2) begin
			err_s2  <= err_s1;
			r400_s2 <= 18'(mag_s1 - 22'(22'(n400) * 22'(DAYS_400Y)));
			yoff_s2 <= 14'(14'(n400) * 14'(YEARS_400));
		end
		if (adv_s3) begin
			err_s3  <= err_s2;
			r100_s3 <= 16'(r400_s2 - 18'(18'(n100) * 18'(DAYS_100Y)));
			yoff_s3 <= yoff_s2 + 14'(14'(n100) * 14'(YEARS_100));
			n100_s3 <= n100;
		end
		if (adv_s4) begin
			err_s4  <= err_s3;
			r100_s4 <= r100_s3;
			yoff_s4 <= yoff_s3;
			n100_s4 <= n100_s3;
			prod_s4 <= 32'(32'(r100_s3) * 32'(RCP_4Y));
		end
		if (adv_s5) begin
			err_s5  <= err_s4;
			r4_s5   <= 11'(r100_s4 - 16'(16'(n4) * 16'(DAYS_4Y)));
			yoff_s5 <= yoff_s4 + 14'({n4, 2'b00});
			p100_s5 <= 8'(BASE_MOD100) + 8'({n4, 2'b00});
			p400_s5 <= 10'(BASE_MOD400) + 10'(10'(n100_s4) * 10'(YEARS_100))
				+ 10'({n4, 2'b00});
		end
		if (adv_s6) begin
			item_s6.err  <= err_s5;
			item_s6.year <= 14'(BASE_YEAR) + yoff_s5 + 14'(n1);
			item_s6.leap <= ((m4 == 2'd0) && (mod100 != 8'd0)) || (mod400 == 10'd0);
			item_s6.doy  <= 9'(r4_s5 - 11'(11'(n1) * 11'(DAYS_1Y)));
		end
	end

	assign out_valid = v_s6;
	assign out_item  = item_s6;

endmodule

// ===== src/dc2d_date.sv =====
module dc2d_date (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  dc2d_pkg::ydoy_t             in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dc2d_pkg::DATE_W-1:0] out_date,
	output logic                        out_err
);
	import dc2d_pkg::*;

	logic v_s7, v_s8;
	logic adv_s7, adv_s8;

	logic              err_s7;
	logic [MON_W-1:0]  mon_s7;
	logic [DOM_W-1:0]  dom_s7;
	logic [YMUL_W-1:0] ymul_s7;
	logic              err_s8;
	logic [DATE_W-1:0] date_s8;

	logic [10:0]       ge;
	logic [MON_W-1:0]  cnt;
	logic [DOY_W-1:0]  first;

	assign adv_s8   = !v_s8 || out_ready;
	assign adv_s7   = !v_s7 || adv_s8;
	assign in_ready = adv_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (adv_s7) v_s7 <= in_valid;
			if (adv_s8) v_s8 <= v_s7;
		end
	end

	// Months already past form a thermometer; its length picks the month
	always_comb begin
		for (int i = 1; i < 12; i++)
			ge[i-1] = in_item.doy >= (in_item.leap ? CUM_LEAP[i] : CUM_NORM[i]);
		cnt   = MON_W'($countones(ge));
		first = in_item.leap ? CUM_LEAP[cnt] : CUM_NORM[cnt];
	end

	always_ff @(posedge clk) begin
		if (adv_s7) begin
			err_s7  <= in_item.err;
			mon_s7  <= cnt + 4'd1;
			dom_s7  <= 5'(in_item.doy - first + 9'd1);
			ymul_s7 <= 28'(28'(in_item.year) * 28'(DEC_YEAR));
		end
		if (adv_s8) begin
			err_s8  <= err_s7;
			date_s8 <= err_s7 ? '0 :
				27'(ymul_s7 + 28'(28'(mon_s7) * 28'(DEC_MONTH)) + 28'(dom_s7));
		end
	end

	assign out_valid = v_s8;
	assign out_date  = date_s8;
	assign out_err   = err_s8;

endmodule

// ===== sim/tb_day_count_to_yyyymmdd.sv =====
module tb_day_count_to_yyyymmdd;
	import dc2d_pkg::*;

	// Calendar spans in days, kept apart from the package so the checker stands on its own
	localparam int unsigned ERA_DAYS  = 146097;	// 400 years
	localparam int unsigned CENT_DAYS = 36524;	// 100 years, last one of an era runs a day longer
	localparam int unsigned QUAD_DAYS = 1461;	// 4 years
	localparam int unsigned YEAR_DAYS = 365;
	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned MAX_DAY   = 4194303;
	localparam int          N_RANDOM  = 1300;
	localparam int          N_DIRECTED = 22;

	// One result as it leaves the block
	typedef struct packed {
		logic              err;
		logic [DATE_W-1:0] date;
	} date_res_t;

	// One row of the directed table; typed rows carry their own answer
	typedef struct packed {
		logic [DAY_W-1:0]  dc;
		logic              typed;
		logic              err;
		logic [DATE_W-1:0] date;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;	// [22:0] day_count (signed), [23] zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;	// [26:0] packed_date, [31:27] zero
	logic [0:0]  m_axis_tuser;	// [0] error

	date_res_t date_q [$];	// dates still owed by the block, oldest first
	int        n_mismatch = 0;
	bit        calm = 1'b0;	// set near the end: no idling on either side
	bit        hold_long_req = 1'b0;	// ask the receiver for one long hold-off
	dir_row_t  dir_tab [N_DIRECTED];

	day_count_to_yyyymmdd u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Split the count into eras, centuries, quads and years, then walk the months.
	function automatic date_res_t civil_date(input logic [DAY_W-1:0] dc);
		int unsigned d;
		int unsigned yr;
		int unsigned n;
		int unsigned mon;
		int unsigned mlen;
		bit          leap;
		date_res_t   r;
		r = '0;
		if (dc[DAY_W-1]) begin
			// negative count: flag it, date stays zero
			r.err = 1'b1;
			return r;
		end
		d  = 32'(dc);
		yr = BASE_YEAR;
		n  = d / ERA_DAYS;
		d  -= n * ERA_DAYS;
		yr += n * 400;
		n  = d / CENT_DAYS;
		if (n > 3)
			n = 3;	// last day of an era stays in the fourth century
		d  -= n * CENT_DAYS;
		yr += n * 100;
		n  = d / QUAD_DAYS;
		d  -= n * QUAD_DAYS;
		yr += n * 4;
		n  = d / YEAR_DAYS;
		if (n > 3)
			n = 3;	// leap day at the end of a quad stays in its fourth year
		d  -= n * YEAR_DAYS;
		yr += n;
		leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		mon  = 1;
		mlen = MONTH_DAYS[0];
		while (mon < 12 && d >= mlen) begin
			d    -= mlen;
			mon++;
			mlen = MONTH_DAYS[mon-1] + ((mon == 2 && leap) ? 1 : 0);
		end
		n = yr * 10000 + mon * 100 + d + 1;
		r.date = n[DATE_W-1:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		n_mismatch++;
	endtask

	// Offer one item and hold it until taken; book its date on acceptance.
	task automatic send_day(input logic [DAY_W-1:0] dc, input date_res_t want);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, dc};
		do
			@(posedge clk);
		while (!s_axis_tready);
		date_q.push_back(want);
	endtask

	// Drop valid for a random burst now and then.
	task automatic sender_gap();
		int unsigned n;
		if (!calm && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 19);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Receiver: random hold-off bursts, plus one long hold-off on request.
	initial begin
		int unsigned n;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long_req) begin
				// hold long enough for the pipeline to fill and back up to the input
				m_axis_tready <= 1'b0;
				for (n = 0; n < 60; n++)
					@(posedge clk);
				hold_long_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 19);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare every taken result against the oldest booked date.
	always @(posedge clk) begin
		date_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (date_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected result date=%0d err=%0b",
					m_axis_tdata[DATE_W-1:0], m_axis_tuser[0]));
			end else begin
				want = date_q.pop_front();
				if (m_axis_tdata[DATE_W-1:0] !== want.date)
					flag_mismatch($sformatf("packed_date got %0d want %0d",
						m_axis_tdata[DATE_W-1:0], want.date));
				if (m_axis_tuser[0] !== want.err)
					flag_mismatch($sformatf("error got %0b want %0b",
						m_axis_tuser[0], want.err));
			end
		end
	end

	// Stimulus: directed table first, then random counts.
	initial begin
		int unsigned v;
		date_res_t   want;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;

		dir_tab = '{
			'{23'd0,       1'b1, 1'b0, 27'd16010101},	// base day
			'{23'd30,      1'b1, 1'b0, 27'd16010131},
			'{23'd31,      1'b1, 1'b0, 27'd16010201},
			'{23'd59,      1'b1, 1'b0, 27'd16010301},
			'{23'd364,     1'b1, 1'b0, 27'd16011231},
			'{23'd365,     1'b1, 1'b0, 27'd16020101},
			'{23'd1154,    1'b1, 1'b0, 27'd16040229},	// leap day
			'{23'd1460,    1'b1, 1'b0, 27'd16041231},	// year split capped at 3
			'{23'd1461,    1'b1, 1'b0, 27'd16050101},
			'{23'd36218,   1'b0, 1'b0, 27'd0},	// March 1 of a non-leap century year
			'{23'd36523,   1'b0, 1'b0, 27'd0},
			'{23'd36524,   1'b0, 1'b0, 27'd0},
			'{23'd146096,  1'b0, 1'b0, 27'd0},	// century split capped at 3
			'{23'd146097,  1'b1, 1'b0, 27'd20010101},
			'{23'd4194302, 1'b0, 1'b0, 27'd0},
			'{23'd4194303, 1'b0, 1'b0, 27'd0},	// largest count
			'{23'h2AAAAA,  1'b0, 1'b0, 27'd0},
			'{23'h155555,  1'b0, 1'b0, 27'd0},
			'{23'h7FFFFF,  1'b1, 1'b1, 27'd0},	// negative counts flag an error
			'{23'h7FFFFE,  1'b1, 1'b1, 27'd0},
			'{23'h400000,  1'b1, 1'b1, 27'd0},
			'{23'h555555,  1'b1, 1'b1, 27'd0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].typed)
				want = '{err: dir_tab[k].err, date: dir_tab[k].date};
			else
				want = civil_date(dir_tab[k].dc);
			send_day(dir_tab[k].dc, want);
			sender_gap();
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 300)
				hold_long_req = 1'b1;	// keep offering while the receiver holds off
			if (i == 600) begin
				// pause until the pipeline has drained completely
				s_axis_tvalid <= 1'b0;
				wait (date_q.size() == 0);
				@(posedge clk);
			end
			if (i == N_RANDOM - 200)
				calm = 1'b1;
			case ($urandom_range(0, 19))
				0, 1, 2: v = $urandom_range(0, 3000);	// early years, every month
				3, 4, 5: begin
					// land on or next to an era, century, quad or year edge
					v = $urandom_range(0, 27) * ERA_DAYS + $urandom_range(0, 3) * CENT_DAYS
						+ $urandom_range(0, 24) * QUAD_DAYS + $urandom_range(0, 3) * YEAR_DAYS
						+ $urandom_range(0, 2);
					if (v > 0 && $urandom_range(0, 1) == 1)
						v = v - 1;
					if (v > MAX_DAY)
						v = MAX_DAY - $urandom_range(0, 3);
				end
				6, 7, 8: v = $urandom_range(0, 4194303) | 32'h0040_0000;	// negative
				default: v = $urandom_range(0, MAX_DAY);
			endcase
			send_day(v[DAY_W-1:0], civil_date(v[DAY_W-1:0]));
			sender_gap();
		end
		s_axis_tvalid <= 1'b0;

		// drain, then allow a few pipeline depths for anything stray
		wait (date_q.size() == 0);
		repeat (24) @(posedge clk);
		if (n_mismatch == 0 && date_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Hard stop if the handshakes ever hang.
	initial begin
		#3000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/dc2d_pkg.sv
src/dc2d_split.sv
src/dc2d_date.sv
src/day_count_to_yyyymmdd.sv
sim/tb_day_count_to_yyyymmdd.sv
